/* design/lph_pkg.sv */
// Shared types and constants for the linear-probe hash table.
`default_nettype none

package lph_pkg;

  localparam int CAP_W = 7;
  localparam int KEY_W = 31;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

  typedef struct packed {
    slot_st_t         st;
    logic [KEY_W-1:0] key;
  } lph_slot_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
  } lph_in_t;

  typedef struct packed {
    logic             success;
    logic [CAP_W-1:0] occupancy;
  } lph_out_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic mod_step;
    logic fetch;
    logic probe;
    logic wr_ins;
    logic wr_tomb;
    logic done;
    logic success;
  } lph_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       mod_last;
    logic       quick_fail;
    logic       is_empty;
    logic       is_match;
    logic       is_tomb;
    logic       last;
    logic       tgt_valid;
    logic [1:0] op;
  } lph_stat_t;

endpackage

`default_nettype wire

/* design/linear_probe_hash_table_unit.sv */
// Top level of the linear-probe hash set: controller plus datapath.
`default_nettype none

// Hash set of 31-bit keys with open addressing and linear probing. Issue a
// word with start while busy is low; opcode picks insert, search or erase.
// Each word not cut short by a cfg_we write yields exactly one result, shown
// on out_word for one cycle with out_strobe high; the receiver has no way to
// hold it off, so capture it then. Timing: an insert on a full table or an
// unknown opcode answers the cycle after acceptance and busy never rises.
// Any other word keeps busy high while the bit-serial remainder of the key
// by the capacity is formed, the first slot is read and then up to capacity
// slots are probed, one per cycle through the slot memory with its separate
// read and write ports. The result appears as busy falls. After reset, and
// after every cfg_we write of capacity, the table is swept empty one slot per
// cycle: busy stays high through the sweep and the occupancy restarts at
// zero. Erase leaves a tombstone; insert walks past tombstones to rule out a
// duplicate and then fills the first tombstone or empty slot it saw.
module linear_probe_hash_table_unit
  import lph_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire lph_in_t          in_word,
  output logic                  out_strobe,
  output lph_out_t              out_word,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data
);

  lph_cmd_t  cmd;
  lph_stat_t st;

  // sequence clearing, remainder, probe and commit
  lph_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_we (cfg_we),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  // hold slots, capacity, live count and the result register
  lph_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

/* design/lph_ctrl.sv */
// Controller state machine for the linear-probe hash table.
`default_nettype none

module lph_ctrl
  import lph_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      cfg_we,
  input  wire lph_stat_t st,
  output lph_cmd_t       cmd,
  output logic           busy
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_FETCH = 5'b01000,
    S_PROBE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (st.quick_fail) begin
            cmd.done = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (st.op == OP_INSERT) begin
          if (st.is_match) begin
            cmd.done = 1'b1;
          end else if (st.is_empty || (st.last && (st.tgt_valid || st.is_tomb))) begin
            cmd.wr_ins  = 1'b1;
            cmd.done    = 1'b1;
            cmd.success = 1'b1;
          end else if (st.last) begin
            cmd.done = 1'b1;
          end
        end else begin
          if (st.is_match) begin
            cmd.wr_tomb = (st.op == OP_ERASE);
            cmd.done    = 1'b1;
            cmd.success = 1'b1;
          end else if (st.is_empty || st.last) begin
            cmd.done = 1'b1;
          end
        end
        if (cmd.done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // a capacity write restarts the clearing pass
    if (cfg_we) begin
      cmd       = '0;
      state_nxt = S_CLEAR;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* design/lph_datapath.sv */
// Datapath of the hash table: slot memory, modulo unit, probe pointer, count.
`default_nettype none

module lph_datapath
  import lph_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lph_in_t          in_word,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire lph_cmd_t         cmd,
  output lph_stat_t             st,
  output logic                  out_strobe,
  output lph_out_t              out_word
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int PW      = (IDX_W > CAP_W) ? IDX_W : CAP_W;
  localparam int BCNT_W  = $clog2(KEY_W);
  localparam int CAP_TOP = (1 << CAP_W) - 1;
  localparam int CAP_MAX = (SLOTS < CAP_TOP) ? SLOTS : CAP_TOP;
  localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);

  lph_slot_t mem [SLOTS];

  logic [CAP_W-1:0]  cap_r, cap_eff;
  logic [CAP_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  clr_idx_r;
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r, kshift_r;
  logic [CAP_W-1:0]  rem_r, rem_nxt;
  logic [CAP_W:0]    rem_sh;
  logic [BCNT_W-1:0] bcnt_r;
  logic [IDX_W-1:0]  pos_r, chk_r, rd_addr, rem_idx, pos_next, tgt_r, ins_idx;
  logic [PW-1:0]     rem_w, pos_inc;
  logic [CAP_W-1:0]  n_r;
  logic              tgt_valid_r;
  lph_slot_t         rd_q;
  logic              we;
  logic [IDX_W-1:0]  wa;
  lph_slot_t         wd;
  logic              out_strobe_r;
  lph_out_t          out_word_r;

  // effective capacity: zero reads as one, clamp to the table size
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_MAX_V) begin
      cap_eff = CAP_MAX_V;
    end else begin
      cap_eff = cap_r;
    end
  end

  // restoring remainder, one key bit per cycle
  always_comb begin
    rem_sh = {rem_r, kshift_r[KEY_W-1]};
    if (rem_sh >= {1'b0, cap_eff}) begin
      rem_nxt = CAP_W'(rem_sh - {1'b0, cap_eff});
    end else begin
      rem_nxt = rem_sh[CAP_W-1:0];
    end
  end

  assign rem_w   = PW'(rem_r);
  assign rem_idx = rem_w[IDX_W-1:0];
  assign rd_addr = cmd.fetch ? rem_idx : pos_r;
  assign pos_inc = PW'(rd_addr) + PW'(1);
  assign pos_next = (pos_inc == PW'(cap_eff)) ? '0 : pos_inc[IDX_W-1:0];
  assign ins_idx = tgt_valid_r ? tgt_r : chk_r;

  // write port: clearing pass, insert, tombstone
  always_comb begin
    we = 1'b0;
    wa = clr_idx_r;
    wd = '{st: ST_EMPTY, key: '0};
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.wr_ins) begin
      we = 1'b1;
      wa = ins_idx;
      wd = '{st: ST_USED, key: key_r};
    end else if (cmd.wr_tomb) begin
      we = 1'b1;
      wa = chk_r;
      wd = '{st: ST_TOMB, key: rd_q.key};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_ins) begin
      count_nxt = count_r + CAP_W'(1);
    end else if (cmd.wr_tomb && count_r != '0) begin
      count_nxt = count_r - CAP_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      count_r      <= '0;
      clr_idx_r    <= '0;
      tgt_valid_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.done;
      if (cfg_we) begin
        cap_r     <= cfg_data;
        count_r   <= '0;
        clr_idx_r <= '0;
      end else begin
        count_r <= count_nxt;
        if (cmd.clr_step) begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
        end
      end
      if (cmd.fetch) begin
        tgt_valid_r <= 1'b0;
      end else if (cmd.probe && st.is_tomb && !tgt_valid_r) begin
        tgt_valid_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_word.opcode;
      key_r    <= in_word.key;
      kshift_r <= in_word.key;
      rem_r    <= '0;
      bcnt_r   <= '0;
    end else if (cmd.mod_step) begin
      kshift_r <= kshift_r << 1;
      rem_r    <= rem_nxt;
      bcnt_r   <= bcnt_r + BCNT_W'(1);
    end
    chk_r <= rd_addr;
    pos_r <= pos_next;
    if (cmd.fetch) begin
      n_r <= '0;
    end else if (cmd.probe) begin
      n_r <= n_r + CAP_W'(1);
    end
    if (cmd.probe && rd_q.st == ST_TOMB && !tgt_valid_r) begin
      tgt_r <= chk_r;
    end
    out_word_r <= '{success: cmd.success, occupancy: count_nxt};
  end

  always_comb begin
    st            = '0;
    st.clr_last   = (clr_idx_r == IDX_W'(SLOTS - 1));
    st.mod_last   = (bcnt_r == BCNT_W'(KEY_W - 1));
    st.is_empty   = (rd_q.st == ST_EMPTY);
    st.is_tomb    = (rd_q.st == ST_TOMB);
    st.is_match   = (rd_q.st == ST_USED) && (rd_q.key == key_r);
    st.last       = (n_r == cap_eff - CAP_W'(1));
    st.tgt_valid  = tgt_valid_r;
    st.op         = op_r;
    if (in_word.opcode == OP_INSERT) begin
      st.quick_fail = (count_r >= cap_eff);
    end else begin
      st.quick_fail = !(in_word.opcode inside {OP_SEARCH, OP_ERASE});
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

/* design/lph_checker.sv */
// Port-level checks for the hash table, bound to the top level.
`default_nettype none

module lph_checker
  import lph_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire lph_in_t          in_word,
  input wire logic             out_strobe,
  input wire lph_out_t         out_word,
  input wire logic             cfg_we,
  input wire logic [CAP_W-1:0] cfg_data
);

  logic [CAP_W-1:0] prev_occ_r;

  // track the last reported occupancy; a clear restarts it at zero
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      prev_occ_r <= '0;
    end else if (out_strobe) begin
      prev_occ_r <= out_word.occupancy;
    end
  end

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> busy && !out_strobe)
    else $error("no clearing pass after reset");

  a_cfg_clears : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("no clearing pass after capacity write");

  a_accept_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted word neither answered nor in progress");

  a_fail_keeps_occ : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.success) |-> (out_word.occupancy == prev_occ_r))
    else $error("failed operation changed occupancy");

  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_word.occupancy) <= SLOTS))
    else $error("occupancy above table size");

  logic unused_ok;
  assign unused_ok = ^{in_word, cfg_data};

endmodule

bind linear_probe_hash_table_unit lph_checker #(
  .SLOTS (SLOTS)
) u_lph_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word),
  .cfg_we     (cfg_we),
  .cfg_data   (cfg_data)
);

`default_nettype wire
